// ===== hdl/olst_pkg.sv =====
// Shared types and constants for the ordered list engine.
// No dependencies; the datapath, controller and engine core in hdl/ import this package.
`default_nettype none

package olst_pkg;

  // default store depth
  localparam int OLST_CAPACITY = 64;

  // command opcodes (code 7 is unused and leaves the list unchanged)
  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_POP_FRONT  = 3'd2;
  localparam logic [2:0] OP_POP_BACK   = 3'd3;
  localparam logic [2:0] OP_REMOVE     = 3'd4;
  localparam logic [2:0] OP_FIND       = 3'd5;
  localparam logic [2:0] OP_REVERSE    = 3'd6;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  // datapath commands issued by the controller, one per cycle
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_PUSH,
    CMD_SET_FULL,
    CMD_SET_EMPTY,
    CMD_SET_NOTFOUND,
    CMD_POP_ADDR,
    CMD_POP_TAKE,
    CMD_SRCH_ADDR,
    CMD_SRCH_HIT,
    CMD_SRCH_NEXT,
    CMD_SH_RD,
    CMD_SH_WR,
    CMD_REM_END,
    CMD_REVERSE,
    CMD_EMIT
  } cmd_t;

  // datapath status flags seen by the controller
  typedef struct packed {
    logic [2:0] op;          // latched opcode
    logic       full;        // count equals capacity
    logic       empty;       // count is zero
    logic       hit;         // read data equals search value
    logic       last_idx;    // search index is the last entry
    logic       off_zero;    // removal offset is the physical front
    logic       shift_more;  // an entry follows the removal offset
    logic       shift_next;  // another entry follows after this shift step
    logic       out_free;    // result register can take a beat
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== hdl/olst_if.sv =====
// Handshake channels of the ordered list engine: command in, result out.
// Depends on nothing; valid/ready with the payload fields of one beat.
`default_nettype none

interface olst_cmd_if;
  logic              valid;
  logic              ready;
  logic [2:0]        opcode;
  logic signed [31:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface olst_res_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] data;
  logic [5:0]         position;
  logic [6:0]         entry_count;

  modport source (output valid, output status, output data, output position,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input data, input position,
                  input entry_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/olst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are undefined until written.
`default_nettype none

module olst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ===== hdl/olst_datapath.sv =====
// Datapath: circular store, front/count/direction registers, search and
// shift address generation, result register. Uses olst_pkg and olst_ram.
`default_nettype none

module olst_datapath #(
  parameter int CAPACITY = olst_pkg::OLST_CAPACITY
) (
  input  logic               clk,
  input  logic               rst_n,
  input  olst_pkg::cmd_t     cmd,
  output olst_pkg::dp_stat_t stat,
  input  logic [2:0]         in_opcode,
  input  logic signed [31:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         out_status,
  output logic signed [31:0] out_data,
  output logic [5:0]         out_position,
  output logic [6:0]         out_entry_count
);
  import olst_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [AW:0]   CAP_W = (AW+1)'(CAPACITY);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  // physical slot of offset off from base, modulo the capacity
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= CAP_W) begin
      s = s - CAP_W;
    end
    return s[AW-1:0];
  endfunction

  // control state
  logic [AW-1:0] front_r;
  logic [CW-1:0] cnt_r;
  logic          rev_r;
  logic          out_valid_r;

  // per-command working registers
  logic [2:0]         op_r;
  logic signed [31:0] val_r;
  logic [CW-1:0]      idx_r;
  logic [AW-1:0]      off_r;
  status_t            status_r;
  logic signed [31:0] data_r;
  logic [5:0]         pos_r;

  // result register
  logic [1:0]         res_status_r;
  logic signed [31:0] res_data_r;
  logic [5:0]         res_pos_r;
  logic [6:0]         res_cnt_r;

  // store ports
  logic          we;
  logic [AW-1:0] waddr;
  logic [31:0]   wdata;
  logic [AW-1:0] raddr;
  logic [31:0]   rdata;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] log_off;
  logic [CW-1:0] pop_off;
  logic          push_front_side;
  logic [AW-1:0] front_dec;
  logic [AW-1:0] front_inc;
  logic [AW-1:0] off_p1;
  logic [CW:0]   off_ext;
  logic          out_free;

  // address arithmetic
  always_comb begin
    cnt_m1          = cnt_r - 1'b1;
    log_off         = rev_r ? (cnt_m1 - idx_r) : idx_r;
    pop_off         = ((op_r == OP_POP_FRONT) != rev_r) ? '0 : cnt_m1;
    push_front_side = (op_r == OP_PUSH_FRONT) != rev_r;
    front_dec       = (front_r == '0) ? AW'(CAPACITY - 1) : front_r - 1'b1;
    front_inc       = (front_r == AW'(CAPACITY - 1)) ? '0 : front_r + 1'b1;
    off_p1          = off_r + 1'b1;
    off_ext         = (CW+1)'(off_r);
    out_free        = !out_valid_r || out_ready;
  end

  // store read address
  always_comb begin
    unique case (cmd)
      CMD_POP_ADDR:  raddr = wrap_add(front_r, pop_off[AW-1:0]);
      CMD_SRCH_ADDR: raddr = wrap_add(front_r, log_off[AW-1:0]);
      default:       raddr = wrap_add(front_r, off_p1);
    endcase
  end

  // store write: push, or closing up after a middle removal
  always_comb begin
    we    = (cmd == CMD_PUSH) || (cmd == CMD_SH_WR);
    waddr = wrap_add(front_r, off_r);
    wdata = rdata;
    if (cmd == CMD_PUSH) begin
      waddr = push_front_side ? front_dec : wrap_add(front_r, cnt_r[AW-1:0]);
      wdata = val_r;
    end
  end

  olst_ram #(
    .WIDTH (32),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // status to the controller
  always_comb begin
    stat.op         = op_r;
    stat.full       = cnt_r == CAP_C;
    stat.empty      = cnt_r == '0;
    stat.hit        = rdata == val_r;
    stat.last_idx   = idx_r == cnt_m1;
    stat.off_zero   = off_r == '0;
    stat.shift_more = (off_ext + 1'b1) < (CW+1)'(cnt_r);
    stat.shift_next = (off_ext + 2'd2) < (CW+1)'(cnt_r);
    stat.out_free   = out_free;
  end

  // list state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      cnt_r       <= '0;
      rev_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      unique case (cmd)
        CMD_PUSH: begin
          if (push_front_side) begin
            front_r <= front_dec;
          end
          cnt_r <= cnt_r + 1'b1;
        end
        CMD_REM_END: begin
          cnt_r <= cnt_m1;
          if (cnt_m1 == '0) begin
            front_r <= '0;
          end else if (off_r == '0) begin
            front_r <= front_inc;
          end
        end
        CMD_REVERSE: begin
          if (cnt_r > CW'(1)) begin
            rev_r <= ~rev_r;
          end
        end
        default: ;
      endcase
      if (cmd == CMD_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk) begin
    unique case (cmd)
      CMD_LOAD: begin
        op_r     <= in_opcode;
        val_r    <= in_value;
        idx_r    <= '0;
        status_r <= ST_OK;
        data_r   <= '0;
        pos_r    <= '0;
      end
      CMD_SET_FULL:     status_r <= ST_FULL;
      CMD_SET_EMPTY:    status_r <= ST_EMPTY;
      CMD_SET_NOTFOUND: status_r <= ST_NOTFOUND;
      CMD_POP_ADDR:     off_r    <= pop_off[AW-1:0];
      CMD_POP_TAKE:     data_r   <= rdata;
      CMD_SRCH_ADDR:    off_r    <= log_off[AW-1:0];
      CMD_SRCH_HIT: begin
        data_r <= val_r;
        pos_r  <= 6'(idx_r);
      end
      CMD_SRCH_NEXT:    idx_r    <= idx_r + 1'b1;
      CMD_SH_WR:        off_r    <= off_p1;
      CMD_EMIT: begin
        res_status_r <= status_r;
        res_data_r   <= data_r;
        res_pos_r    <= pos_r;
        res_cnt_r    <= 7'(cnt_r);
      end
      default: ;
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_status      = res_status_r;
  assign out_data        = res_data_r;
  assign out_position    = res_pos_r;
  assign out_entry_count = res_cnt_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CAP_C) else $error("entry count above capacity");

  a_empty_front: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> front_r == '0) else $error("empty list with moved front");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_EMIT |-> out_free) else $error("result overwritten");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_PUSH |-> cnt_r != CAP_C) else $error("push into full store");

endmodule

`default_nettype wire

// ===== hdl/olst_ctrl.sv =====
// Controller: sequences one command beat through dispatch, search, shift
// and result stages. Uses olst_pkg; drives olst_datapath commands.
`default_nettype none

module olst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output olst_pkg::cmd_t     cmd,
  input  olst_pkg::dp_stat_t stat
);
  import olst_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_POP_TAKE,
    S_SRCH_ADDR,
    S_SRCH_CMP,
    S_SH_RD,
    S_SH_WR,
    S_REM_END,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // next state and command for this cycle
  always_comb begin
    state_nxt = state_r;
    cmd       = CMD_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd       = CMD_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        state_nxt = S_FINISH;
        unique case (stat.op)
          OP_PUSH_FRONT, OP_PUSH_BACK: begin
            cmd = stat.full ? CMD_SET_FULL : CMD_PUSH;
          end
          OP_POP_FRONT, OP_POP_BACK: begin
            if (stat.empty) begin
              cmd = CMD_SET_EMPTY;
            end else begin
              cmd       = CMD_POP_ADDR;
              state_nxt = S_POP_TAKE;
            end
          end
          OP_REMOVE, OP_FIND: begin
            if (stat.empty) begin
              cmd = CMD_SET_NOTFOUND;
            end else begin
              cmd       = CMD_SRCH_ADDR;
              state_nxt = S_SRCH_CMP;
            end
          end
          OP_REVERSE: cmd = CMD_REVERSE;
          default:    cmd = CMD_NONE;
        endcase
      end
      // pops take an end entry, so nothing needs closing up
      S_POP_TAKE: begin
        cmd       = CMD_POP_TAKE;
        state_nxt = S_REM_END;
      end
      S_SRCH_ADDR: begin
        cmd       = CMD_SRCH_ADDR;
        state_nxt = S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        if (stat.hit) begin
          cmd = CMD_SRCH_HIT;
          if (stat.op != OP_REMOVE) begin
            state_nxt = S_FINISH;
          end else if (stat.off_zero || !stat.shift_more) begin
            state_nxt = S_REM_END;
          end else begin
            state_nxt = S_SH_RD;
          end
        end else if (stat.last_idx) begin
          cmd       = CMD_SET_NOTFOUND;
          state_nxt = S_FINISH;
        end else begin
          cmd       = CMD_SRCH_NEXT;
          state_nxt = S_SRCH_ADDR;
        end
      end
      S_SH_RD: begin
        cmd       = CMD_SH_RD;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        cmd       = CMD_SH_WR;
        state_nxt = stat.shift_next ? S_SH_RD : S_REM_END;
      end
      S_REM_END: begin
        cmd       = CMD_REM_END;
        state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd       = CMD_EMIT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  // checks
  a_shift_remove: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SH_WR |-> stat.op == OP_REMOVE) else $error("shift outside remove");

  a_wr_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SH_WR |-> $past(state_r) == S_SH_RD) else $error("shift write without read");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd == CMD_EMIT |=> state_r == S_IDLE) else $error("no return to idle after result");

endmodule

`default_nettype wire

// ===== hdl/ordered_list_engine_core.sv =====
// Ordered list engine: bounded deque of signed 32-bit values with find/remove.
// Push, reverse and the empty or full cases go from dispatch straight to the result beat;
// pops read the end entry, then take it; find reads and compares each entry examined in
// turn; remove then reads and rewrites each entry it closes up, via the single store read port.
// One command at a time; the next is taken once the result sits in the output register.
// Reset (rst_n low, synchronous) empties the list and clears direction; store data is not cleared.
`default_nettype none

module ordered_list_engine_core #(
  parameter int CAPACITY = olst_pkg::OLST_CAPACITY
) (
  input  logic      clk,
  input  logic      rst_n,
  olst_cmd_if.sink  in_cmd,
  olst_res_if.source out_res
);
  import olst_pkg::*;

  cmd_t     cmd;
  dp_stat_t stat;
  logic     in_ready;

  olst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_cmd.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  olst_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_opcode       (in_cmd.opcode),
    .in_value        (in_cmd.value),
    .out_valid       (out_res.valid),
    .out_ready       (out_res.ready),
    .out_status      (out_res.status),
    .out_data        (out_res.data),
    .out_position    (out_res.position),
    .out_entry_count (out_res.entry_count)
  );

  assign in_cmd.ready = in_ready;

endmodule

`default_nettype wire

// ===== bench/olst_list_checker.sv =====
// Result checker for the ordered list engine: predicts every result beat from the
// accepted command beats and compares. Depends on olst_pkg and the channels in olst_if.
`default_nettype none

module olst_list_checker #(
  parameter int CAPACITY = olst_pkg::OLST_CAPACITY
) (
  input  logic clk,
  input  logic rst_n,
  olst_cmd_if  cmd,
  olst_res_if  res,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import olst_pkg::*;

  typedef struct packed {
    status_t            status;
    logic signed [31:0] data;
    logic [5:0]         position;
    logic [6:0]         entry_count;
  } list_result_t;

  // shadow copy of the list: circular store, head slot, fill level, direction
  logic signed [31:0] slot_val [CAPACITY];
  int unsigned        head_slot;
  int unsigned        held;
  bit                 flipped;

  // results owed by the block, oldest first
  list_result_t       owed_results[$];

  // physical slot at offset k from the head
  function automatic int unsigned slot_at(int unsigned k);
    return (head_slot + k) % CAPACITY;
  endfunction

  // offset from the head of logical position pos
  function automatic int unsigned offset_of(int unsigned pos);
    return flipped ? held - 1 - pos : pos;
  endfunction

  // take out the entry at offset k; later entries close up behind it
  function automatic logic signed [31:0] take_offset(int unsigned k);
    logic signed [31:0] v;
    v = slot_val[slot_at(k)];
    if (k == 0) begin
      head_slot = (head_slot + 1) % CAPACITY;
    end else begin
      for (int unsigned j = k; j + 1 < held; j++)
        slot_val[slot_at(j)] = slot_val[slot_at(j + 1)];
    end
    held--;
    if (held == 0) head_slot = 0;
    return v;
  endfunction

  // apply one command to the shadow list and return the result it should give
  function automatic list_result_t apply_list_cmd(logic [2:0] op, logic signed [31:0] val);
    list_result_t r;
    int unsigned  hit;
    r.status   = ST_OK;
    r.data     = '0;
    r.position = '0;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (held >= CAPACITY) begin
          r.status = ST_FULL;
        end else if ((op == OP_PUSH_FRONT) != flipped) begin
          head_slot = (head_slot + CAPACITY - 1) % CAPACITY;
          slot_val[head_slot] = val;
          held++;
        end else begin
          slot_val[slot_at(held)] = val;
          held++;
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (held == 0) r.status = ST_EMPTY;
        else r.data = take_offset(offset_of(op == OP_POP_FRONT ? 0 : held - 1));
      end
      OP_REMOVE, OP_FIND: begin
        hit = held;
        for (int unsigned i = 0; i < held; i++) begin
          if (slot_val[slot_at(offset_of(i))] == val) begin
            hit = i;
            break;
          end
        end
        if (hit >= held) begin
          r.status = ST_NOTFOUND;
        end else begin
          r.position = hit[5:0];
          r.data     = (op == OP_REMOVE) ? take_offset(offset_of(hit)) : val;
        end
      end
      OP_REVERSE: begin
        if (held > 1) flipped = !flipped;
      end
      default: ;
    endcase
    r.entry_count = held[6:0];
    return r;
  endfunction

  // predict on command beats, compare on result beats
  always @(posedge clk) begin : watch
    list_result_t got;
    list_result_t want;
    if (!rst_n) begin
      head_slot = 0;
      held      = 0;
      flipped   = 1'b0;
      owed_results.delete();
    end else begin
      if (cmd.valid && cmd.ready)
        owed_results.push_back(apply_list_cmd(cmd.opcode, cmd.value));
      if (res.valid && res.ready) begin
        got.status      = status_t'(res.status);
        got.data        = res.data;
        got.position    = res.position;
        got.entry_count = res.entry_count;
        if (owed_results.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result beat with none owed: status %0d data %0d pos %0d count %0d",
                     $realtime, got.status, got.data, got.position, got.entry_count);
          fail_count++;
        end else begin
          want = owed_results.pop_front();
          if (got.status !== want.status || got.data !== want.data ||
              got.position !== want.position || got.entry_count !== want.entry_count) begin
            if (fail_count < 10)
              $display({"%0t: result mismatch: expected status %0d data %0d pos %0d count %0d,",
                        " got status %0d data %0d pos %0d count %0d"},
                       $realtime, want.status, want.data, want.position, want.entry_count,
                       got.status, got.data, got.position, got.entry_count);
            fail_count++;
          end
        end
      end
    end
    pending = owed_results.size();
  end

endmodule

`default_nettype wire

// ===== bench/tb_ordered_list_engine_core.sv =====
// Top of the ordered list engine regression: clock, reset, command stimulus and verdict.
// Depends on olst_pkg, olst_if, the engine core and olst_list_checker.
`default_nettype none

module tb_ordered_list_engine_core;
  timeunit 1ns;
  timeprecision 1ps;
  import olst_pkg::*;

  localparam logic [2:0] OP_UNUSED   = 3'd7;
  localparam int         ROUNDS      = 8;
  localparam int         ROUND_ITEMS = 250;
  localparam int         TAIL_CYCLES = 400;
  localparam int         CYCLE_LIMIT = 4_000_000;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} mix_t;

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cycle_count;
  bit   no_idle;

  logic signed [31:0] value_pool [6];

  olst_cmd_if cmd_if ();
  olst_res_if res_if ();

  ordered_list_engine_core #(.CAPACITY(OLST_CAPACITY)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_cmd (cmd_if),
    .out_res(res_if)
  );

  olst_list_checker #(.CAPACITY(OLST_CAPACITY)) list_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_if),
    .res       (res_if),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // run limit
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ordered_list_engine_core regression: fail");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // result side stalls
  initial begin
    int stall;
    res_if.ready = 1'b0;
    @(posedge clk);
    forever begin
      res_if.ready <= 1'b1;
      repeat (($urandom_range(0, 99) < 85) ? $urandom_range(1, 12) : $urandom_range(40, 150))
        @(posedge clk);
      stall = idle_gap();
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // one command beat; valid stays up into the next call when no gap follows
  task automatic send_cmd(input logic [2:0] op, input logic signed [31:0] val);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      cmd_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_if.valid  <= 1'b1;
    cmd_if.opcode <= op;
    cmd_if.value  <= val;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
  endtask

  // small value set per round so finds and removes hit, with duplicates
  task automatic refill_pool();
    for (int k = 0; k < 6; k++) begin
      case ($urandom_range(0, 3))
        0: value_pool[k] = $urandom;
        1: value_pool[k] = $urandom_range(0, 1) ? VAL_MIN : VAL_MAX;
        default: value_pool[k] = int'($urandom_range(0, 10)) - 5;
      endcase
    end
  endtask

  function automatic logic signed [31:0] pick_value();
    if ($urandom_range(0, 99) < 75) return value_pool[$urandom_range(0, 5)];
    return $urandom;
  endfunction

  // operation mix leaning toward filling, draining or neither
  function automatic logic [2:0] pick_op(mix_t mix);
    int r;
    int push_w, pop_w, rem_w, find_w, rev_w;
    case (mix)
      MIX_FILL:  begin push_w = 70; pop_w = 8;  rem_w = 8;  find_w = 8;  rev_w = 4; end
      MIX_DRAIN: begin push_w = 20; pop_w = 45; rem_w = 15; find_w = 12; rev_w = 6; end
      default:   begin push_w = 40; pop_w = 25; rem_w = 12; find_w = 15; rev_w = 6; end
    endcase
    r = $urandom_range(0, 99);
    if (r < push_w) return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    r -= push_w;
    if (r < pop_w) return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    r -= pop_w;
    if (r < rem_w) return OP_REMOVE;
    r -= rem_w;
    if (r < find_w) return OP_FIND;
    r -= find_w;
    if (r < rev_w) return OP_REVERSE;
    return OP_UNUSED;
  endfunction

  // stimulus and verdict
  initial begin
    rst_n         = 1'b0;
    no_idle       = 1'b0;
    cmd_if.valid  = 1'b0;
    cmd_if.opcode = OP_PUSH_FRONT;
    cmd_if.value  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list: pops, misses, reverse and the unused code
    send_cmd(OP_POP_FRONT, 32'sd0);
    send_cmd(OP_POP_BACK, 32'sd0);
    send_cmd(OP_FIND, 32'sd0);
    send_cmd(OP_REMOVE, 32'sd5);
    send_cmd(OP_REVERSE, 32'sd0);
    send_cmd(OP_UNUSED, VAL_MAX);
    // single entry reverse, then build [0, MIN, MAX, -1]
    send_cmd(OP_PUSH_FRONT, VAL_MIN);
    send_cmd(OP_REVERSE, 32'sd0);
    send_cmd(OP_PUSH_BACK, VAL_MAX);
    send_cmd(OP_PUSH_FRONT, 32'sd0);
    send_cmd(OP_PUSH_BACK, -32'sd1);
    // positions before and after a reverse
    send_cmd(OP_FIND, -32'sd1);
    send_cmd(OP_REVERSE, 32'sd0);
    send_cmd(OP_FIND, -32'sd1);
    send_cmd(OP_FIND, VAL_MIN);
    // duplicate values: first match goes, then a middle removal
    send_cmd(OP_PUSH_FRONT, VAL_MIN);
    send_cmd(OP_REMOVE, VAL_MIN);
    send_cmd(OP_REMOVE, VAL_MIN);
    send_cmd(OP_REMOVE, 32'sd42);
    send_cmd(OP_UNUSED, -32'sd1);
    // drain to empty and reuse
    send_cmd(OP_POP_BACK, 32'sd0);
    send_cmd(OP_POP_FRONT, 32'sd0);
    send_cmd(OP_REMOVE, VAL_MAX);
    send_cmd(OP_PUSH_BACK, 32'sd7);
    send_cmd(OP_FIND, 32'sd7);

    // random rounds: fill past full, drain past empty, mixed traffic
    for (int rnd = 0; rnd < ROUNDS; rnd++) begin
      refill_pool();
      no_idle = ($urandom_range(0, 3) == 0);
      for (int n = 0; n < ROUND_ITEMS; n++)
        send_cmd(pick_op(mix_t'(rnd % 3)), pick_value());
    end
    cmd_if.valid <= 1'b0;
    no_idle = 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("ordered_list_engine_core regression: pass");
    end else begin
      $display("ordered_list_engine_core regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
